FILE: hdl/ikhm_pkg.sv
`default_nettype none
package ikhm_pkg;

	// default sizes of the table
	localparam int NUM_BUCKETS_DEF = 64;
	localparam int WAYS_DEF        = 4;
	localparam int KEY_BITS_DEF    = 32;
	localparam int VALUE_BITS_DEF  = 32;

	// command field and bucket count register
	localparam int CMD_W = 2;
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

	// status codes
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// divider control from the sequencer
	typedef struct packed {
		logic             start;
		logic [CFG_W-1:0] divisor;
	} div_req_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic             done;
		logic [CFG_W-1:0] rem;
	} div_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/ikhm_if.sv
`default_nettype none
// request channel: command, key and value
interface ikhm_req_if
	import ikhm_pkg::*;
#(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      cmd;
	logic [KEY_BITS-1:0]   key;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output cmd, output key, output value, input ready);
	modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

// response channel: found flag, previous value and status
interface ikhm_rsp_if
	import ikhm_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic [VALUE_BITS-1:0] old_value;
	logic                  status;

	modport source (output valid, output found, output old_value, output status, input ready);
	modport sink   (input valid, input found, input old_value, input status, output ready);
endinterface
`default_nettype wire

FILE: hdl/integer_key_hash_map_core.sv
`default_nettype none
// channel   dir  fields                       accepted when
// req       in   cmd, key, value              req.valid and req.ready
// rsp       out  found, old_value, status     rsp.valid and rsp.ready
// cfg       in   cfg_wdata (bucket count)     cfg_we
//
// an item goes from acceptance to result through key modulo bucket count in the shared
// divider, then row read, read return and update
// req is ready again in the cycle the result enters the output register, one word at a time
// after reset a clearing pass over all NUM_BUCKETS rows wipes the valid bits, req not ready
// a waiting result sits in the output register; the next word is accepted meanwhile
// and only its update stalls until rsp is free
module integer_key_hash_map_core
	import ikhm_pkg::*;
#(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int WAYS        = WAYS_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	ikhm_req_if.sink              req,
	ikhm_rsp_if.source            rsp
);

	localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_READ  = 5'b01000,
		ST_EVAL  = 5'b10000
	} state_t;

	state_t                state_q;
	logic [BKT_W-1:0]      clr_cnt_q;
	logic [CFG_W-1:0]      bucket_count_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [BKT_W-1:0]      bkt_q;

	logic                  rsp_valid_q;
	logic                  found_q;
	logic [VALUE_BITS-1:0] old_value_q;
	logic                  status_q;

	logic                  accept;
	logic                  eval_go;
	logic [CFG_W-1:0]      bc_eff;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	logic                  rd_en;
	logic [BKT_W-1:0]      rd_addr;
	logic [WAYS-1:0]              rd_valid;
	logic [WAYS*KEY_BITS-1:0]     rd_key;
	logic [WAYS*VALUE_BITS-1:0]   rd_data;
	logic                         wr_en;
	logic [BKT_W-1:0]             wr_addr;
	logic [WAYS-1:0]              wr_valid;
	logic [WAYS*KEY_BITS-1:0]     wr_key;
	logic [WAYS*VALUE_BITS-1:0]   wr_data;

	logic [WAYS-1:0]              hit_vec;
	logic [WAYS-1:0]              free_vec;
	logic [WAYS-1:0]              hit_1h;
	logic [WAYS-1:0]              free_1h;
	logic                         any_hit;
	logic                         any_free;
	logic                         is_ins;
	logic [VALUE_BITS-1:0]        hit_data;
	logic [WAYS-1:0]              new_valid;
	logic [WAYS*KEY_BITS-1:0]     new_key;
	logic [WAYS*VALUE_BITS-1:0]   new_data;
	logic                         status_next;

	assign accept  = req.valid && req.ready;
	assign eval_go = (state_q == ST_EVAL) && (!rsp_valid_q || rsp.ready);
	assign req.ready = (state_q == ST_IDLE);

	// bucket count in use: zero counts as one, clipped to the table size
	always_comb begin
		if (bucket_count_q == '0) begin
			bc_eff = CFG_W'(1);
		end else if (32'(bucket_count_q) > 32'(NUM_BUCKETS)) begin
			bc_eff = CFG_W'(NUM_BUCKETS);
		end else begin
			bc_eff = bucket_count_q;
		end
	end

	// bucket count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CFG_RESET;
		end else if (cfg_we) begin
			bucket_count_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + BKT_W'(1);
					if (clr_cnt_q == BKT_W'(NUM_BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (eval_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.cmd;
			key_q   <= req.key;
			value_q <= req.value;
		end
		if (rd_en) begin
			bkt_q <= rd_addr;
		end
	end

	// shared modulo unit
	assign div_req.start   = accept;
	assign div_req.divisor = bc_eff;

	ikhm_divider #(
		.KEY_BITS (KEY_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.key    (req.key),
		.rsp    (div_rsp)
	);

	// bucket row read once the remainder is ready
	assign rd_en   = (state_q == ST_DIV) && div_rsp.done;
	assign rd_addr = BKT_W'(div_rsp.rem);

	// way search and row update
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w]  = rd_valid[w] && (rd_key[w*KEY_BITS +: KEY_BITS] == key_q);
			free_vec[w] = !rd_valid[w];
		end
		hit_1h   = hit_vec & (~hit_vec + WAYS'(1));
		free_1h  = free_vec & (~free_vec + WAYS'(1));
		any_hit  = |hit_vec;
		any_free = |free_vec;
		is_ins   = cmd_q inside {CMD_INSERT, CMD_ADD};

		hit_data = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (hit_1h[w]) begin
				hit_data = hit_data | rd_data[w*VALUE_BITS +: VALUE_BITS];
			end
		end

		new_valid   = rd_valid;
		new_key     = rd_key;
		new_data    = rd_data;
		status_next = STATUS_DONE;
		if (any_hit) begin
			for (int w = 0; w < WAYS; w++) begin
				if (hit_1h[w] && (cmd_q == CMD_INSERT)) begin
					new_data[w*VALUE_BITS +: VALUE_BITS] = value_q;
				end
				if (hit_1h[w] && (cmd_q == CMD_DELETE)) begin
					new_valid[w] = 1'b0;
				end
			end
		end else if (is_ins) begin
			if (any_free) begin
				for (int w = 0; w < WAYS; w++) begin
					if (free_1h[w]) begin
						new_valid[w]                         = 1'b1;
						new_key[w*KEY_BITS +: KEY_BITS]       = key_q;
						new_data[w*VALUE_BITS +: VALUE_BITS] = value_q;
					end
				end
			end else begin
				status_next = STATUS_FULL;
			end
		end
	end

	// table write: clearing pass or row update
	always_comb begin
		wr_en    = (state_q == ST_CLEAR) || eval_go;
		if (state_q == ST_CLEAR) begin
			wr_addr  = clr_cnt_q;
			wr_valid = '0;
			wr_key   = '0;
			wr_data  = '0;
		end else begin
			wr_addr  = bkt_q;
			wr_valid = new_valid;
			wr_key   = new_key;
			wr_data  = new_data;
		end
	end

	ikhm_table #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.WAYS        (WAYS),
		.KEY_BITS    (KEY_BITS),
		.VALUE_BITS  (VALUE_BITS)
	) u_table (
		.clk      (clk),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_valid (rd_valid),
		.rd_key   (rd_key),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_valid (wr_valid),
		.wr_key   (wr_key),
		.wr_data  (wr_data)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (eval_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_go) begin
			found_q     <= any_hit;
			old_value_q <= any_hit ? hit_data : '0;
			status_q    <= status_next;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.found     = found_q;
	assign rsp.old_value = old_value_q;
	assign rsp.status    = status_q;

endmodule
`default_nettype wire

FILE: hdl/ikhm_divider.sv
`default_nettype none
// restoring modulo, one key bit per cycle
module ikhm_divider
	import ikhm_pkg::*;
#(
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire div_req_t            req,
	input  wire logic [KEY_BITS-1:0] key,
	output div_rsp_t                 rsp
);

	localparam int CNT_W = $clog2(KEY_BITS + 1);

	logic [KEY_BITS-1:0] shift_q;
	logic [CFG_W-1:0]    rem_q;
	logic [CFG_W-1:0]    div_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [CFG_W:0]      trial;
	logic [CFG_W:0]      diff;
	logic [CFG_W-1:0]    rem_next;

	// one shift, compare and subtract step
	always_comb begin
		trial = {rem_q, shift_q[KEY_BITS-1]};
		diff  = trial - {1'b0, div_q};
		if (trial >= {1'b0, div_q}) begin
			rem_next = diff[CFG_W-1:0];
		end else begin
			rem_next = trial[CFG_W-1:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(KEY_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			shift_q <= key;
			rem_q   <= '0;
			div_q   <= req.divisor;
		end else if (busy_q) begin
			shift_q <= {shift_q[KEY_BITS-2:0], 1'b0};
			rem_q   <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

FILE: hdl/ikhm_table.sv
`default_nettype none
// bucket rows: valid bits, keys and values of all ways of one bucket
module ikhm_table
	import ikhm_pkg::*;
#(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int WAYS        = WAYS_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF,
	localparam int BKT_W      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         rd_en,
	input  wire logic [BKT_W-1:0]             rd_addr,
	output logic      [WAYS-1:0]              rd_valid,
	output logic      [WAYS*KEY_BITS-1:0]     rd_key,
	output logic      [WAYS*VALUE_BITS-1:0]   rd_data,
	input  wire logic                         wr_en,
	input  wire logic [BKT_W-1:0]             wr_addr,
	input  wire logic [WAYS-1:0]              wr_valid,
	input  wire logic [WAYS*KEY_BITS-1:0]     wr_key,
	input  wire logic [WAYS*VALUE_BITS-1:0]   wr_data
);

	logic [WAYS-1:0]            valid_mem [NUM_BUCKETS];
	logic [WAYS*KEY_BITS-1:0]   key_mem   [NUM_BUCKETS];
	logic [WAYS*VALUE_BITS-1:0] data_mem  [NUM_BUCKETS];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			valid_mem[wr_addr] <= wr_valid;
			key_mem[wr_addr]   <= wr_key;
			data_mem[wr_addr]  <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_valid <= valid_mem[rd_addr];
			rd_key   <= key_mem[rd_addr];
			rd_data  <= data_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire
